@@ sv/rsmd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsmd_pkg
// shared types, constants and the sine table for the ray segment distance block
// ----------------------------------------------------------------------------
`default_nettype none

package rsmd_pkg;

    localparam int MAX_SEGMENTS     = 64;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int SEG_AW   = $clog2(MAX_SEGMENTS);
    localparam int SEG_CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int SINE_AW  = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_SH  = 16 - SINE_AW;

    localparam int REG_EDGES_IN_USE    = 0;
    localparam int REG_NO_HIT_DISTANCE = 1;

    localparam logic REQ_SEGMENT = 1'b0;
    localparam logic REQ_RAY     = 1'b1;

    localparam logic [15:0] NO_HIT_RESET = 16'd64000;

    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598668;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026995;
    localparam logic [63:0] C9 = 64'd172272;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_MUL,
        S_SIGN,
        S_TEST,
        S_DIV,
        S_DONE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
    } t_seg;

    typedef struct packed {
        logic              en;
        logic [SEG_AW-1:0] addr;
        t_seg              data;
    } t_seg_wr;

    typedef struct packed {
        logic [6:0]  edges_in_use;
        logic [15:0] no_hit_distance;
    } t_cfg;

    typedef logic signed [15:0] t_sine_tab [SINE_TABLE_DEPTH];

    function automatic logic [15:0] quarter_sine(logic [14:0] r);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] q;
        z  = 64'(r) << 16;
        z2 = (z * z) >> 30;
        s  = C7 - ((z2 * C9) >> 30);
        s  = C5 - ((z2 * s) >> 30);
        s  = C3 - ((z2 * s) >> 30);
        s  = C1 - ((z2 * s) >> 30);
        v  = (z * s) >> 30;
        q  = (v + 64'd32768) >> 16;
        if (q > 64'd16384) begin
            q = 64'd16384;
        end
        return q[15:0];
    endfunction

    function automatic logic signed [15:0] sine16(logic [15:0] a);
        logic [14:0] r;
        logic [15:0] v;
        r = {1'b0, a[13:0]};
        if (a[14]) begin
            r = 15'd16384 - r;
        end
        v = quarter_sine(r);
        return a[15] ? -$signed(v) : $signed(v);
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [31:0] aq;
        for (int p = 0; p < SINE_TABLE_DEPTH; p++) begin
            aq     = 32'(p) << SINE_SH;
            tab[p] = sine16(aq[15:0]);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

@@ sv/rsmd_seg_mem.sv @@
// ----------------------------------------------------------------------------
// rsmd_seg_mem
// segment table, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rsmd_seg_mem (
    input  wire logic                        i_clk,
    input  wire rsmd_pkg::t_seg_wr           i_wr,
    input  wire logic [rsmd_pkg::SEG_AW-1:0] i_rd_addr,
    output rsmd_pkg::t_seg                   o_rd_data
);

    rsmd_pkg::t_seg r_mem [rsmd_pkg::MAX_SEGMENTS];
    rsmd_pkg::t_seg r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ sv/rsmd_core.sv @@
// ----------------------------------------------------------------------------
// rsmd_core
// sequencer with one shared multiplier and a bit-serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module rsmd_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rsmd_pkg::t_cfg     i_cfg,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_req_type,
    input  wire logic [5:0]         i_edge_index,
    input  wire logic signed [15:0] i_seg_start_x,
    input  wire logic signed [15:0] i_seg_start_y,
    input  wire logic signed [15:0] i_seg_end_x,
    input  wire logic signed [15:0] i_seg_end_y,
    input  wire logic signed [15:0] i_ray_origin_x,
    input  wire logic signed [15:0] i_ray_origin_y,
    input  wire logic [15:0]        i_ray_angle,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [15:0]             o_distance,
    output logic                    o_hit
);

    localparam int AW = rsmd_pkg::SEG_AW;
    localparam int CW = rsmd_pkg::SEG_CW;
    localparam int SW = rsmd_pkg::SINE_AW;

    rsmd_pkg::t_state r_state, n_state;

    logic signed [15:0] r_sx, r_cy, r_ox, r_oy;
    logic [CW-1:0]      r_idx, r_n;
    logic [15:0]        r_best;
    logic signed [16:0] r_dx, r_dy, r_px, r_py;
    logic [2:0]         r_step;
    logic signed [33:0] r_prod;
    logic signed [35:0] r_det, r_unum, r_tnum;
    logic [35:0]        r_rem;
    logic [16:0]        r_nlow;
    logic [16:0]        r_q;
    logic [4:0]         r_dcnt;
    logic               r_out_valid;
    logic [15:0]        r_distance;
    logic               r_hit;

    logic               w_accept;
    logic               w_out_free;
    logic               w_hit_ok;
    logic [SW-1:0]      w_sin_idx, w_cos_idx;
    logic [31:0]        w_n_full, w_wr_idx;
    logic signed [16:0] w_ma, w_mb;
    logic signed [35:0] w_prod_ext;
    logic [35:0]        w_trial;
    logic               w_div_last;
    rsmd_pkg::t_seg_wr  w_wr;
    rsmd_pkg::t_seg     w_rd;

    rsmd_seg_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd)
    );

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_sin_idx  = i_ray_angle[15 -: SW];
    assign w_cos_idx  = w_sin_idx + SW'(rsmd_pkg::SINE_TABLE_DEPTH / 4);
    assign w_wr_idx   = 32'(i_edge_index);
    assign w_n_full   = (32'(i_cfg.edges_in_use) > 32'(rsmd_pkg::MAX_SEGMENTS))
                        ? 32'(rsmd_pkg::MAX_SEGMENTS) : 32'(i_cfg.edges_in_use);
    assign w_prod_ext = 36'(r_prod);
    assign w_trial    = {r_rem[34:0], r_nlow[16]};
    assign w_div_last = (r_dcnt == 5'd16);
    assign w_hit_ok   = (r_det != '0) && (r_tnum > 36'sd0) && (r_unum >= 36'sd0)
                        && (r_unum <= r_det) && ((r_tnum >>> 3) < r_det);

    always_comb begin
        case (r_step)
            3'd0:    begin w_ma = 17'(r_sx); w_mb = r_dy; end
            3'd1:    begin w_ma = 17'(r_cy); w_mb = r_dx; end
            3'd2:    begin w_ma = 17'(r_cy); w_mb = r_px; end
            3'd3:    begin w_ma = 17'(r_sx); w_mb = r_py; end
            3'd4:    begin w_ma = r_dy;      w_mb = r_px; end
            3'd5:    begin w_ma = r_dx;      w_mb = r_py; end
            default: begin w_ma = '0;        w_mb = '0;   end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsmd_pkg::S_IDLE: begin
                if (w_accept && i_req_type == rsmd_pkg::REQ_RAY) begin
                    n_state = rsmd_pkg::S_READ;
                end
            end
            rsmd_pkg::S_READ: n_state = (r_idx == r_n) ? rsmd_pkg::S_FIN : rsmd_pkg::S_LOAD;
            rsmd_pkg::S_LOAD: n_state = rsmd_pkg::S_MUL;
            rsmd_pkg::S_MUL: begin
                if (r_step == 3'd6) begin
                    n_state = rsmd_pkg::S_SIGN;
                end
            end
            rsmd_pkg::S_SIGN: n_state = rsmd_pkg::S_TEST;
            rsmd_pkg::S_TEST: n_state = w_hit_ok ? rsmd_pkg::S_DIV : rsmd_pkg::S_DONE;
            rsmd_pkg::S_DIV: begin
                if (w_div_last) begin
                    n_state = rsmd_pkg::S_DONE;
                end
            end
            rsmd_pkg::S_DONE: n_state = rsmd_pkg::S_READ;
            rsmd_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = rsmd_pkg::S_IDLE;
                end
            end
            default: n_state = rsmd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = (r_state != rsmd_pkg::S_IDLE);
        w_wr.en      = w_accept && (i_req_type == rsmd_pkg::REQ_SEGMENT)
                       && (w_wr_idx < 32'(rsmd_pkg::MAX_SEGMENTS));
        w_wr.addr    = w_wr_idx[AW-1:0];
        w_wr.data.x0 = i_seg_start_x;
        w_wr.data.y0 = i_seg_start_y;
        w_wr.data.x1 = i_seg_end_x;
        w_wr.data.y1 = i_seg_end_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsmd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rsmd_pkg::S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            rsmd_pkg::S_IDLE: begin
                r_sx   <= rsmd_pkg::SINE_TAB[w_sin_idx];
                r_cy   <= rsmd_pkg::SINE_TAB[w_cos_idx];
                r_ox   <= i_ray_origin_x;
                r_oy   <= i_ray_origin_y;
                r_best <= i_cfg.no_hit_distance;
                r_n    <= w_n_full[CW-1:0];
                r_idx  <= '0;
            end
            rsmd_pkg::S_LOAD: begin
                r_dx   <= 17'(w_rd.x1) - 17'(w_rd.x0);
                r_dy   <= 17'(w_rd.y1) - 17'(w_rd.y0);
                r_px   <= 17'(w_rd.x0) - 17'(r_ox);
                r_py   <= 17'(w_rd.y0) - 17'(r_oy);
                r_det  <= '0;
                r_unum <= '0;
                r_tnum <= '0;
                r_step <= '0;
            end
            rsmd_pkg::S_MUL: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd1: r_det  <= r_det + w_prod_ext;
                    3'd2: r_det  <= r_det - w_prod_ext;
                    3'd3: r_unum <= r_unum + w_prod_ext;
                    3'd4: r_unum <= r_unum - w_prod_ext;
                    3'd5: r_tnum <= r_tnum + w_prod_ext;
                    3'd6: r_tnum <= r_tnum - w_prod_ext;
                    default: ;
                endcase
            end
            rsmd_pkg::S_SIGN: begin
                if (r_det < 36'sd0) begin
                    r_det  <= -r_det;
                    r_unum <= -r_unum;
                    r_tnum <= -r_tnum;
                end
            end
            rsmd_pkg::S_TEST: begin
                r_rem  <= 36'(r_tnum >>> 3);
                r_nlow <= {r_tnum[2:0], 14'd0};
                r_q    <= '0;
                r_dcnt <= '0;
            end
            rsmd_pkg::S_DIV: begin
                r_dcnt <= r_dcnt + 5'd1;
                r_nlow <= {r_nlow[15:0], 1'b0};
                if (w_trial >= 36'(r_det)) begin
                    r_rem <= w_trial - 36'(r_det);
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[15:0], 1'b0};
                end
            end
            rsmd_pkg::S_DONE: begin
                if (r_q != '0 || r_dcnt != '0) begin
                    if (r_q < {1'b0, r_best}) begin
                        r_best <= r_q[15:0];
                    end
                end
                r_dcnt <= '0;
                r_q    <= '0;
                r_idx  <= r_idx + CW'(1);
            end
            rsmd_pkg::S_FIN: begin
                if (w_out_free) begin
                    r_distance <= r_best;
                    r_hit      <= (r_best < i_cfg.no_hit_distance);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_hit       = r_hit;

endmodule

`default_nettype wire

@@ sv/ray_segment_min_distance.sv @@
// ----------------------------------------------------------------------------
// ray_segment_min_distance
// nearest hit of a cast ray against a table of map segments
//
// input channel (i_in_valid / o_in_stall) takes one item per handshake:
// req_type 0 writes a segment into the table, no result.
// req_type 1 casts a ray and gives one result item on the output channel
// (o_out_valid / i_out_stall) with distance and hit flag.
// a ray holds the block until every tested segment is done; each one passes
// through the states read, load, mul, sign, test, div (only if it survives the
// hit test) and done, then fin registers the result. every segment takes one
// table read, six products through the one shared 17x17 multiplier and,
// if it is a candidate hit, 17 steps of the bit-serial divider.
// o_in_stall is high for the whole ray; the result sits in an output
// register and the block returns to idle once it is loaded, so the next
// item is taken while a result still waits. a stalled output holds.
// reset clears the sequencer, the output valid and both registers
// (edges_in_use 0, no_hit_distance 64000); the segment table is not
// cleared. registers: edges_in_use at 0x0, no_hit_distance at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_segment_min_distance (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_req_type,
    input  wire logic [5:0]         i_edge_index,
    input  wire logic signed [15:0] i_seg_start_x,
    input  wire logic signed [15:0] i_seg_start_y,
    input  wire logic signed [15:0] i_seg_end_x,
    input  wire logic signed [15:0] i_seg_end_y,
    input  wire logic signed [15:0] i_ray_origin_x,
    input  wire logic signed [15:0] i_ray_origin_y,
    input  wire logic [15:0]        i_ray_angle,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [15:0]             o_distance,
    output logic                    o_hit
);

    rsmd_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edges_in_use    <= '0;
            r_cfg.no_hit_distance <= rsmd_pkg::NO_HIT_RESET;
        end else if (w_wr) begin
            if (32'(paddr[2]) == rsmd_pkg::REG_EDGES_IN_USE) begin
                r_cfg.edges_in_use <= pwdata[6:0];
            end else begin
                r_cfg.no_hit_distance <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (32'(paddr[2]) == rsmd_pkg::REG_NO_HIT_DISTANCE) begin
            prdata = {16'd0, r_cfg.no_hit_distance};
        end else begin
            prdata = {25'd0, r_cfg.edges_in_use};
        end
    end

    rsmd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_edge_index   (i_edge_index),
        .i_seg_start_x  (i_seg_start_x),
        .i_seg_start_y  (i_seg_start_y),
        .i_seg_end_x    (i_seg_end_x),
        .i_seg_end_y    (i_seg_end_y),
        .i_ray_origin_x (i_ray_origin_x),
        .i_ray_origin_y (i_ray_origin_y),
        .i_ray_angle    (i_ray_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_distance     (o_distance),
        .o_hit          (o_hit)
    );

endmodule

`default_nettype wire
